[design/soc_pkg.sv]
// ----------------------------------------------------------------------------
// soc_pkg - shared definitions for the substring occurrence counter
// Field widths, register indexes, case folding and the step struct.
// ----------------------------------------------------------------------------
package soc_pkg;

	localparam int CHAR_W          = 8;
	localparam int COUNT_W         = 32;
	localparam int LEN_W           = 5;
	localparam int CFG_W           = 64;
	localparam int CFG_IDX_W       = 2;
	localparam int PAT_CHARS       = 16;
	localparam int MAX_PATTERN_DEF = 16;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;

	localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] ASCII_CASE_OFS = 8'h20;

	typedef logic [CHAR_W-1:0] char_t;

	// one text word moving through the matcher
	typedef struct packed {
		logic  step;   // word consumed this cycle
		logic  clear;  // word ends the text
		char_t chr;    // folded character
	} step_t;

	function automatic char_t fold_case(input char_t c);
		char_t r;
		r = c;
		if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
			r = c + ASCII_CASE_OFS;
		end
		return r;
	endfunction

endpackage

[design/soc_matcher.sv]
// ----------------------------------------------------------------------------
// soc_matcher - character window and pattern compare
// Holds the last folded characters of the text and flags a pattern hit
// ending at the character on offer.
// ----------------------------------------------------------------------------
module soc_matcher
	import soc_pkg::*;
#(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  step_t                       step_in,
	input  logic [2*CFG_W-1:0]          pattern_chars,
	input  logic [LEN_W-1:0]            pattern_length,
	output logic                        hit
);

	localparam int WIN_DEPTH = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
	localparam int IDX_W     = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
	localparam int SEEN_W    = $clog2(WIN_DEPTH + 1);
	localparam int SUM_W     = LEN_W + 1;
	localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_PATTERN - 1);
	localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_PATTERN);

	// window entries are only read once written (gated by seen_q)
	char_t              win_q [WIN_DEPTH];
	logic [SEEN_W-1:0]  seen_q;
	char_t              pat_f [PAT_CHARS];
	logic [LEN_W-1:0]   len_eff;

	always_comb begin
		for (int i = 0; i < PAT_CHARS; i++) begin
			pat_f[i] = fold_case(pattern_chars[i*CHAR_W +: CHAR_W]);
		end
		len_eff = (pattern_length > LEN_MAX) ? LEN_MAX : pattern_length;
	end

	always_comb begin
		logic [LEN_W-1:0] pos;
		logic             tail_ok;
		logic [3:0]       last_idx;
		pos      = '0;
		tail_ok  = 1'b1;
		last_idx = 4'(len_eff - LEN_W'(1));
		// window entry 0 is the newest; it lines up with the character just
		// before the final one of the pattern
		for (int k = 0; k < MAX_PATTERN - 1; k++) begin
			if (LEN_W'(k + 1) < len_eff) begin
				pos = len_eff - LEN_W'(k + 2);
				if (win_q[pos[IDX_W-1:0]] != pat_f[k]) begin
					tail_ok = 1'b0;
				end
			end
		end
		if (len_eff == '0) begin
			hit = 1'b1;
		end else if (SUM_W'(seen_q) + SUM_W'(1) < SUM_W'(len_eff)) begin
			hit = 1'b0;
		end else begin
			hit = tail_ok && (pat_f[last_idx] == step_in.chr);
		end
	end

	always_ff @(posedge clk) begin
		if (step_in.step) begin
			win_q[0] <= step_in.chr;
			for (int i = 1; i < WIN_DEPTH; i++) begin
				win_q[i] <= win_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (step_in.step) begin
			if (step_in.clear) begin
				seen_q <= '0;
			end else if (seen_q < SEEN_MAX) begin
				seen_q <= seen_q + SEEN_W'(1);
			end
		end
	end

endmodule

[design/substring_occurrence_counter.sv]
// ----------------------------------------------------------------------------
// substring_occurrence_counter - case-insensitive pattern occurrence count
// Counts overlapping occurrences of a pattern of up to MAX_PATTERN
// characters in a byte stream and reports the total at the end of the text.
// ----------------------------------------------------------------------------
// Usage:
//  - Load the pattern through cfg_wr_en/cfg_index/cfg_data while idle:
//    index 0 = characters 0..7, 1 = characters 8..15, 2 = length (0..16).
//    A length of zero counts every character; above MAX_PATTERN it clamps.
//  - Text words enter on the s_ side, one byte per word, s_tlast on the
//    final byte. Letters are folded to lower case on both sides.
//  - One result word leaves on the m_ side per text: the saturating count.
// After the last word is accepted, the count reaches m_tvalid through
// the input register, then the result register; it waits longer only while
// the previous count is still held on the m_ side.
// Throughput: one word per cycle; the compare against the window is a
// single combinational pass. Only a last word waits, and only while the
// previous result is still held on the m_ side; words behind it wait too.
// Reset clears the counters, fill count and both valid flags; the pattern
// registers reset to zero (empty pattern).
// ----------------------------------------------------------------------------
module substring_occurrence_counter
	import soc_pkg::*;
#(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// text in
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [CHAR_W-1:0]    s_tdata,   // [7:0] text_char
	input  logic                 s_tlast,   // last_char
	// count out
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [COUNT_W-1:0]   m_tdata,   // [31:0] match_count
	// configuration
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// pattern registers
	logic [CFG_W-1:0]   pat_low_q;
	logic [CFG_W-1:0]   pat_high_q;
	logic [LEN_W-1:0]   pat_len_q;

	// input stage
	logic               valid_s1;
	logic               last_s1;
	char_t              char_s1;

	// result stage
	logic               out_valid_q;
	logic [COUNT_W-1:0] out_count_q;
	logic [COUNT_W-1:0] running_q;

	logic               adv_s1;
	logic               hit;
	logic [COUNT_W-1:0] count_next;
	step_t              step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			pat_len_q  <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PATTERN_LOW:  pat_low_q  <= cfg_data;
				REG_PATTERN_HIGH: pat_high_q <= cfg_data;
				REG_PATTERN_LEN:  pat_len_q  <= cfg_data[LEN_W-1:0];
				default:          ;
			endcase
		end
	end

	// a last word may only move on when the result register is free or is emptied in the same cycle
	assign adv_s1   = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= fold_case(s_tdata);
			last_s1 <= s_tlast;
		end
	end

	assign step.step  = adv_s1;
	assign step.clear = last_s1;
	assign step.chr   = char_s1;

	soc_matcher #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_matcher (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_in       (step),
		.pattern_chars ({pat_high_q, pat_low_q}),
		.pattern_length(pat_len_q),
		.hit           (hit)
	);

	// saturating count including this word
	assign count_next = (hit && running_q != COUNT_MAX) ? running_q + COUNT_W'(1) : running_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
		end else if (adv_s1) begin
			running_q <= last_s1 ? '0 : count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			out_count_q <= count_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_count_q;

	// a finished text always lands in the result register
	a_last_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> out_valid_q)
		else $error("last word advanced without a result");

	// a held result is never overwritten by the next text
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && out_valid_q && !m_tready |-> !adv_s1)
		else $error("result overwritten while stalled");

	// the running count starts from zero after each text
	a_clear_count: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> running_q == '0)
		else $error("running count not cleared at end of text");

	// saturation holds within a text
	a_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && !last_s1 && running_q == COUNT_MAX |=> running_q == COUNT_MAX)
		else $error("running count wrapped");

endmodule
